>>> sv/msst_pkg.sv
// ----------------------------------------------------------------------------
// msst_pkg
// shared types and constants of the multi-slot software timer
// ----------------------------------------------------------------------------
package msst_pkg;

  // most results one tick may give
  localparam int MaxResults = 8;
  localparam int FiredW     = $clog2(MaxResults + 1);

  // fixed field widths
  localparam int SlotW   = 3;
  localparam int PeriodW = 32;
  localparam int RepeatW = 16;
  localparam int TagW    = 8;
  localparam int NowW    = 32;

  typedef enum logic [1:0] {
    CmdTick     = 2'd0,
    CmdSet      = 2'd1,
    CmdUnset    = 2'd2,
    CmdUnsetAll = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindFired = 2'd0,
    KindSetOk = 2'd1,
    KindFull  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  // scan token walking down the row of slot cells
  typedef struct packed {
    logic              valid;
    logic              is_tick;
    logic [FiredW-1:0] fired;
    logic              found;
  } tok_t;

  // result offered by the cell that holds the token
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [TagW-1:0]  tag;
  } emit_t;

endpackage

>>> sv/msst_cell.sv
// ----------------------------------------------------------------------------
// msst_cell
// one timer slot; evaluates the scan token and hands it to the next cell
// ----------------------------------------------------------------------------
module msst_cell #(
  parameter int IDX        = 0,
  parameter int TIME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msst_pkg::tok_t                tok_i,
  output msst_pkg::tok_t                tok_o,
  output msst_pkg::emit_t               emit_o,
  input  logic                          emit_ok_i,
  input  logic [TIME_WIDTH-1:0]         time_i,
  input  logic [msst_pkg::PeriodW-1:0]  period_i,
  input  logic [msst_pkg::RepeatW-1:0]  repeat_i,
  input  logic [msst_pkg::TagW-1:0]     tag_i,
  input  logic                          clr_all_i,
  input  logic                          clr_one_i,
  input  logic [msst_pkg::SlotW-1:0]    clr_idx_i
);

  localparam logic [msst_pkg::SlotW-1:0] SlotId = msst_pkg::SlotW'(IDX % 8);
  localparam bit Addressable = (IDX < 8);

  msst_pkg::tok_t                 tok_q;
  logic                           active_q;
  logic [msst_pkg::PeriodW-1:0]   period_q;
  logic [TIME_WIDTH-1:0]          deadline_q;
  logic signed [msst_pkg::RepeatW-1:0] remain_q;
  logic [msst_pkg::TagW-1:0]      tag_q;

  logic due, fire, claim, stall, adv;
  logic [TIME_WIDTH-1:0] reload;
  logic [TIME_WIDTH-1:0] setload;

  always_comb begin
    due   = active_q && !(deadline_q > time_i);
    fire  = tok_q.valid && tok_q.is_tick && due &&
            (tok_q.fired != msst_pkg::FiredW'(msst_pkg::MaxResults));
    claim = tok_q.valid && !tok_q.is_tick && !active_q && !tok_q.found;
    stall = (fire || claim) && !emit_ok_i;
    adv   = tok_q.valid && !stall;

    reload  = time_i + TIME_WIDTH'(period_q);
    setload = time_i + TIME_WIDTH'(period_i);

    // all zero unless offering, so the row can be merged with an or
    emit_o = '0;
    if (fire || claim) begin
      emit_o.valid = 1'b1;
      emit_o.kind  = fire ? msst_pkg::KindFired : msst_pkg::KindSetOk;
      emit_o.slot  = SlotId;
      emit_o.tag   = fire ? tag_q : '0;
    end

    tok_o.valid   = adv;
    tok_o.is_tick = tok_q.is_tick;
    tok_o.fired   = tok_q.fired + msst_pkg::FiredW'(fire);
    tok_o.found   = tok_q.found | claim;
  end

  // token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (tok_i.valid) begin
      tok_q <= tok_i;
    end else if (adv) begin
      tok_q.valid <= 1'b0;
    end
  end

  // slot valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (clr_all_i || (clr_one_i && Addressable && (clr_idx_i == SlotId))) begin
      active_q <= 1'b0;
    end else if (adv && claim) begin
      active_q <= 1'b1;
    end else if (adv && fire && (remain_q == msst_pkg::RepeatW'(1))) begin
      active_q <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (adv && claim) begin
      period_q   <= period_i;
      remain_q   <= repeat_i;
      tag_q      <= tag_i;
      deadline_q <= setload;
    end else if (adv && fire) begin
      deadline_q <= reload;
      if (remain_q > 0) begin
        remain_q <= remain_q - msst_pkg::RepeatW'(1);
      end
    end
  end

endmodule

>>> sv/multi_slot_software_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_software_timer
// table of timer slots, one cell per slot, scanned by a walking token
// ----------------------------------------------------------------------------
// tick and set: the token walks one cell per cycle down the row, except while
//   the result side stalls it
// unset and unset-all: done in the accept cycle; the block stays ready for the next request
// one tick or set at a time: no new request is taken until the cell row walk finishes
// reset: time zero, every slot free, no result pending
module multi_slot_software_timer #(
  parameter int SLOTS      = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [msst_pkg::PeriodW-1:0]  period_i,
  input  logic [msst_pkg::RepeatW-1:0]  repeat_count_i,
  input  logic [msst_pkg::TagW-1:0]     event_tag_i,
  input  logic [msst_pkg::SlotW-1:0]    slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [msst_pkg::SlotW-1:0]    slot_o,
  output logic [msst_pkg::TagW-1:0]     fired_tag_o,
  output logic [msst_pkg::NowW-1:0]     now_o,
  output logic                          last_o
);

  // result held until we know whether it is the final one
  typedef struct packed {
    msst_pkg::kind_e                kind;
    logic [msst_pkg::SlotW-1:0]     slot;
    logic [msst_pkg::TagW-1:0]      tag;
    logic [msst_pkg::NowW-1:0]      now;
  } res_t;

  msst_pkg::state_e state_q, state_d;

  logic [TIME_WIDTH-1:0]          time_q;
  logic [msst_pkg::PeriodW-1:0]   period_q;
  logic [msst_pkg::RepeatW-1:0]   repeat_q;
  logic [msst_pkg::TagW-1:0]      tag_q;

  // pending result and output register
  logic pend_v_q;
  res_t pend_q;
  logic out_v_q;
  res_t out_q;
  logic out_last_q;

  // what the finished token reported
  logic fin_tick_q, fin_found_q;

  msst_pkg::tok_t  tok [SLOTS+1];
  msst_pkg::emit_t emits [SLOTS];
  msst_pkg::emit_t emit;

  logic accept, out_free, emit_ok, take_emit;
  logic do_clr_all, do_clr_one, start_scan;
  logic fin_push, fin_full;
  logic load_out;
  res_t out_d;
  logic out_last_d;

  assign in_ready_o = (state_q == msst_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_v_q || out_ready_i;
  assign emit_ok    = !pend_v_q || out_free;

  // decode the request
  always_comb begin
    do_clr_all = 1'b0;
    do_clr_one = 1'b0;
    start_scan = 1'b0;
    unique case (msst_pkg::cmd_e'(cmd_i))
      msst_pkg::CmdTick:     start_scan = accept;
      msst_pkg::CmdSet:      start_scan = accept;
      msst_pkg::CmdUnset:    do_clr_one = accept;
      msst_pkg::CmdUnsetAll: do_clr_all = accept;
    endcase
  end

  // token injected at the head of the row
  always_comb begin
    tok[0].valid   = start_scan;
    tok[0].is_tick = (cmd_i == msst_pkg::CmdTick);
    tok[0].fired   = '0;
    tok[0].found   = 1'b0;
  end

  // at most one cell holds the token, so a plain or picks its offer
  always_comb begin
    emit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      emit = emit | emits[i];
    end
  end

  assign take_emit = emit.valid && emit_ok;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    msst_cell #(
      .IDX       (g),
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .emit_o   (emits[g]),
      .emit_ok_i(emit_ok),
      .time_i   (time_q),
      .period_i (period_q),
      .repeat_i (repeat_q),
      .tag_i    (tag_q),
      .clr_all_i(do_clr_all),
      .clr_one_i(do_clr_one),
      .clr_idx_i(slot_index_i)
    );
  end

  // next state and finishing actions
  always_comb begin
    state_d  = state_q;
    fin_push = 1'b0;
    fin_full = 1'b0;
    unique case (state_q)
      msst_pkg::StIdle: begin
        if (start_scan) state_d = msst_pkg::StScan;
      end
      msst_pkg::StScan: begin
        // token left the last cell
        if (tok[SLOTS].valid) state_d = msst_pkg::StFinish;
      end
      msst_pkg::StFinish: begin
        // a set that found no free slot reports the table full
        if (!fin_tick_q && !fin_found_q) begin
          if (out_free) begin
            fin_full = 1'b1;
            state_d  = msst_pkg::StIdle;
          end
        end else if (pend_v_q) begin
          if (out_free) begin
            fin_push = 1'b1;
            state_d  = msst_pkg::StIdle;
          end
        end else begin
          // quiet tick
          state_d = msst_pkg::StIdle;
        end
      end
      default: state_d = msst_pkg::StIdle;
    endcase
  end

  // output register load
  always_comb begin
    load_out   = fin_full || fin_push || (take_emit && pend_v_q);
    out_last_d = fin_full || fin_push;
    if (fin_full) begin
      out_d.kind = msst_pkg::KindFull;
      out_d.slot = '0;
      out_d.tag  = '0;
      out_d.now  = msst_pkg::NowW'(time_q);
    end else begin
      out_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msst_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // time base and captured set payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (accept && (cmd_i == msst_pkg::CmdTick)) begin
      time_q <= time_q + TIME_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      period_q <= period_i;
      repeat_q <= repeat_count_i;
      tag_q    <= event_tag_i;
    end
  end

  // token summary at the end of the row
  always_ff @(posedge clk_i) begin
    if (tok[SLOTS].valid) begin
      fin_tick_q  <= tok[SLOTS].is_tick;
      fin_found_q <= tok[SLOTS].found;
    end
  end

  // pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (take_emit) begin
      pend_v_q <= 1'b1;
    end else if (fin_push) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_emit) begin
      pend_q.kind <= emit.kind;
      pend_q.slot <= emit.slot;
      pend_q.tag  <= emit.tag;
      pend_q.now  <= msst_pkg::NowW'(time_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_q.kind;
  assign slot_o      = out_q.slot;
  assign fired_tag_o = out_q.tag;
  assign now_o       = out_q.now;
  assign last_o      = out_last_q;

endmodule
